// File: design/nonuniform_grid_derivative_top_defines.svh
// Assertion macros for the checker file of the derivative block
`ifndef NONUNIFORM_GRID_DERIVATIVE_TOP_DEFINES_SVH
`define NONUNIFORM_GRID_DERIVATIVE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define NGD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("derivative block check failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define NGD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("derivative block check failed");

`endif

// File: design/ngd_pkg.sv
// Package: constants, types and helper functions of the derivative block
`timescale 1ns / 1ps
package ngd_pkg;

    localparam int BLOCK_POINTS = 8;
    localparam int MAX_STENCIL  = 7;
    localparam int AW  = $clog2(BLOCK_POINTS);
    localparam int OW  = AW + 2;
    localparam int NW  = $clog2(MAX_STENCIL + 1);
    localparam int CAP = ((MAX_STENCIL % 2) == 0) ? MAX_STENCIL - 1 : MAX_STENCIL;

    localparam int DIV_STEPS = 79;
    localparam int MUL_STEPS = 33;
    localparam int CW = $clog2(DIV_STEPS + 1);

    localparam logic signed [63:0] SAT_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_NEG = -64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] Q32_ONE = 63'h1_0000_0000;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_WIDE = 2'd1;
    localparam logic [1:0] FAULT_DIV0 = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic          wr;
        logic [AW-1:0] wr_addr;
        logic          rd;
        logic [AW-1:0] rd_addr;
        logic          lat_xp;
        logic          lat_xi;
        logic          lat_xj;
        logic          w_init;
        logic          w_one;
        logic          centre;
        logic          div_go;
        logic          mul_d_go;
        logic          mul_y_go;
        logic          w_from_div;
        logic          w_from_mul;
        logic          acc_add;
        logic          pt_clr;
        logic [1:0]    fault_set;
    } ngd_cmd_t;

    // status from the datapath
    typedef struct packed {
        logic arith_done;
        logic diff_zero;
    } ngd_sts_t;

    typedef enum logic { OP_MUL, OP_DIV } ngd_op_t;

    // saturating add to +-(2^63-1)
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({SAT_POS[63], SAT_POS}))
            return SAT_POS;
        else if (s < $signed({SAT_NEG[63], SAT_NEG}))
            return SAT_NEG;
        else
            return s[63:0];
    endfunction

    // stencil width in use for a register value
    function automatic logic [NW-1:0] eff_width(input logic [2:0] s);
        int n;
        n = int'(s);
        if (n < 1)
            n = 1;
        if ((n % 2) == 0)
            n = n - 1;
        if (n > CAP)
            n = CAP;
        return NW'(n);
    endfunction

endpackage

// File: design/ngd_arith.sv
// Shared serial unit: shift-add multiplier and restoring divider
`timescale 1ns / 1ps
module ngd_arith import ngd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  ngd_op_t     op,
    input  logic        sh32,
    input  logic [62:0] a_mag,
    input  logic [32:0] b_mag,
    output logic        done,
    output logic [62:0] res_mag
);

    logic          busy_reg;
    logic          done_reg;
    ngd_op_t       op_reg;
    logic          sh32_reg;
    logic [CW-1:0] cnt_reg;
    logic [62:0]   a_reg;
    logic [32:0]   b_reg;
    logic [32:0]   rem_reg;
    logic [78:0]   q_reg;
    logic [95:0]   prod_reg;

    logic [33:0]   rem_sh;
    logic          q_bit;
    logic [33:0]   rem_sub;
    logic [79:0]   prod_shr;
    logic          last;

    // one divide step
    always_comb begin
        rem_sh  = {rem_reg, q_reg[78]};
        q_bit   = (rem_sh >= {1'b0, b_reg});
        rem_sub = q_bit ? (rem_sh - {1'b0, b_reg}) : rem_sh;
    end

    assign last = (op_reg == OP_DIV) ? (cnt_reg == CW'(DIV_STEPS - 1))
                                     : (cnt_reg == CW'(MUL_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operand and iteration registers
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= op;
            sh32_reg <= sh32;
            cnt_reg  <= '0;
            a_reg    <= a_mag;
            b_reg    <= b_mag;
            rem_reg  <= '0;
            q_reg    <= {a_mag, 16'h0000};
            prod_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (op_reg == OP_DIV) begin
                rem_reg <= rem_sub[32:0];
                q_reg   <= {q_reg[77:0], q_bit};
            end else begin
                prod_reg <= {prod_reg[94:0], 1'b0}
                            + (b_reg[32] ? {33'h0, a_reg} : 96'h0);
                b_reg    <= {b_reg[31:0], 1'b0};
            end
        end
    end

    // scale and saturate the final value
    always_comb begin
        prod_shr = sh32_reg ? {16'h0000, prod_reg[95:32]} : prod_reg[95:16];
        if (op_reg == OP_DIV)
            res_mag = (q_reg[78:63] != 16'h0000) ? SAT_POS[62:0] : q_reg[62:0];
        else
            res_mag = (prod_shr[79:63] != 17'h0) ? SAT_POS[62:0] : prod_shr[62:0];
    end

    assign done = done_reg;

endmodule

// File: design/ngd_dp.sv
// Datapath: sample stores, operand registers, weight and accumulator
`timescale 1ns / 1ps
module ngd_dp import ngd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ngd_cmd_t           cmd,
    input  logic signed [31:0] s_abscissa,
    input  logic signed [31:0] s_ordinate,
    output ngd_sts_t           sts,
    output logic signed [31:0] slope,
    output logic [1:0]         fault
);

    logic [31:0] pos_mem [BLOCK_POINTS];
    logic [31:0] val_mem [BLOCK_POINTS];
    logic [31:0] pos_q_reg;
    logic [31:0] val_q_reg;

    logic signed [31:0] xp_reg;
    logic signed [31:0] xi_reg;
    logic signed [31:0] xj_reg;
    logic signed [31:0] yi_reg;
    logic signed [63:0] w_reg;
    logic signed [63:0] acc_reg;
    logic [1:0]         fault_reg;
    logic               neg_reg;

    logic signed [32:0] diff;
    logic signed [32:0] pdiff;
    logic [32:0]        diff_mag;
    logic [32:0]        pdiff_mag;
    logic [32:0]        y_mag;
    logic [63:0]        w_mag;
    logic [63:0]        acc_mag;
    logic [47:0]        sl_mag;

    logic               a_start;
    ngd_op_t            a_op;
    logic [62:0]        a_in;
    logic [32:0]        b_in;
    logic               a_done;
    logic [62:0]        a_res;
    logic signed [63:0] s_res;

    // sample stores, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            pos_mem[cmd.wr_addr] <= s_abscissa;
            val_mem[cmd.wr_addr] <= s_ordinate;
        end
        if (cmd.rd) begin
            pos_q_reg <= pos_mem[cmd.rd_addr];
            val_q_reg <= val_mem[cmd.rd_addr];
        end
    end

    // differences and magnitudes
    always_comb begin
        diff      = (cmd.centre ? {xp_reg[31], xp_reg} : {xi_reg[31], xi_reg})
                    - {xj_reg[31], xj_reg};
        pdiff     = {xp_reg[31], xp_reg} - {xj_reg[31], xj_reg};
        diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
        pdiff_mag = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
        y_mag     = yi_reg[31] ? 33'(-{yi_reg[31], yi_reg}) : {1'b0, yi_reg};
        w_mag     = w_reg[63] ? 64'(-w_reg) : 64'(w_reg);
    end

    // operand selection for the shared unit
    always_comb begin
        a_start = cmd.div_go | cmd.mul_d_go | cmd.mul_y_go;
        a_op    = cmd.div_go ? OP_DIV : OP_MUL;
        a_in    = (cmd.div_go && cmd.centre) ? Q32_ONE : w_mag[62:0];
        if (cmd.div_go)
            b_in = diff_mag;
        else if (cmd.mul_d_go)
            b_in = pdiff_mag;
        else
            b_in = y_mag;
    end

    ngd_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (a_start),
        .op      (a_op),
        .sh32    (cmd.mul_y_go),
        .a_mag   (a_in),
        .b_mag   (b_in),
        .done    (a_done),
        .res_mag (a_res)
    );

    assign s_res = neg_reg ? -signed'({1'b0, a_res}) : signed'({1'b0, a_res});

    // result sign fixed at launch
    always_ff @(posedge aclk) begin
        if (cmd.div_go)
            neg_reg <= cmd.centre ? diff[32] : (w_reg[63] ^ diff[32]);
        else if (cmd.mul_d_go)
            neg_reg <= w_reg[63] ^ pdiff[32];
        else if (cmd.mul_y_go)
            neg_reg <= w_reg[63] ^ yi_reg[31];
    end

    // operand registers
    always_ff @(posedge aclk) begin
        if (cmd.lat_xp)
            xp_reg <= pos_q_reg;
        if (cmd.lat_xi) begin
            xi_reg <= pos_q_reg;
            yi_reg <= val_q_reg;
        end
        if (cmd.lat_xj)
            xj_reg <= pos_q_reg;
    end

    // weight and accumulator
    always_ff @(posedge aclk) begin
        if (cmd.w_init)
            w_reg <= cmd.w_one ? signed'({1'b0, Q32_ONE}) : 64'sh0;
        else if (cmd.w_from_div)
            w_reg <= cmd.centre ? sat_add(w_reg, s_res) : s_res;
        else if (cmd.w_from_mul)
            w_reg <= s_res;
        if (cmd.pt_clr)
            acc_reg <= 64'sh0;
        else if (cmd.acc_add)
            acc_reg <= sat_add(acc_reg, s_res);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            fault_reg <= FAULT_NONE;
        else if (cmd.pt_clr || cmd.fault_set != FAULT_NONE)
            fault_reg <= cmd.fault_set;
    end

    // slope: drop the fraction bits of the Q16.16 sum and saturate
    always_comb begin
        acc_mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        sl_mag  = acc_mag[63:16];
        if (fault_reg != FAULT_NONE)
            slope = 32'sh0;
        else if (acc_reg[63])
            slope = (sl_mag > 48'h8000_0000) ? 32'sh8000_0000 : 32'(-sl_mag);
        else
            slope = (sl_mag > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(sl_mag);
    end

    assign fault          = fault_reg;
    assign sts.arith_done = a_done;
    assign sts.diff_zero  = (diff == 33'sh0);

endmodule

// File: design/ngd_ctrl.sv
// Controller: load sequencing and stencil loops over points and offsets
`timescale 1ns / 1ps
module ngd_ctrl import ngd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [2:0]    stencil,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [AW-1:0] point,
    output ngd_cmd_t      cmd,
    input  ngd_sts_t      sts
);

    typedef enum logic [3:0] {
        S_LOAD, S_PSTART, S_GETXP, S_ISTART, S_GETXI, S_JCHK, S_GETXJ,
        S_DCHK, S_DIV, S_MGO, S_MUL, S_TERM, S_TMUL, S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        load_reg, load_next;
    logic [AW-1:0]        p_reg, p_next;
    logic signed [OW-1:0] i_reg, i_next;
    logic signed [OW-1:0] j_reg, j_next;
    logic signed [OW-1:0] start_reg, start_next;
    logic signed [OW-1:0] end_reg, end_next;

    logic [NW-1:0]        n_eff;
    logic                 too_wide;
    logic signed [OW-1:0] p_off;
    logic signed [OW-1:0] addr_i;
    logic signed [OW-1:0] addr_j;
    int                   pn, nn, mid;

    assign n_eff    = eff_width(stencil);
    assign too_wide = (int'(n_eff) > BLOCK_POINTS);
    assign p_off    = signed'(OW'(p_reg));
    assign addr_i   = p_off + i_reg;
    assign addr_j   = p_off + j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            load_reg  <= '0;
            p_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            start_reg <= '0;
            end_reg   <= '0;
        end else begin
            state_reg <= state_next;
            load_reg  <= load_next;
            p_reg     <= p_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_next  = load_reg;
        p_next     = p_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        start_next = start_reg;
        end_next   = end_reg;
        cmd        = '0;
        cmd.wr_addr = load_reg;
        cmd.centre  = (i_reg == '0);
        pn  = int'(p_reg);
        nn  = int'(n_eff);
        mid = (nn - 1) >> 1;

        case (state_reg)
            // take a block of samples
            S_LOAD: begin
                if (s_valid) begin
                    cmd.wr = 1'b1;
                    if (load_reg == AW'(BLOCK_POINTS - 1)) begin
                        load_next  = '0;
                        p_next     = '0;
                        state_next = S_PSTART;
                    end else begin
                        load_next = load_reg + AW'(1);
                    end
                end
            end
            // stencil bounds for this point
            S_PSTART: begin
                cmd.pt_clr    = 1'b1;
                cmd.fault_set = too_wide ? FAULT_WIDE : FAULT_NONE;
                cmd.rd        = 1'b1;
                cmd.rd_addr   = p_reg;
                if (pn < mid) begin
                    start_next = OW'(-pn);
                    end_next   = OW'(nn - pn);
                end else if (BLOCK_POINTS - pn - 1 < mid) begin
                    start_next = OW'(BLOCK_POINTS - nn - pn);
                    end_next   = OW'(BLOCK_POINTS - pn);
                end else begin
                    start_next = OW'(-mid);
                    end_next   = OW'(mid + 1);
                end
                state_next = too_wide ? S_EMIT : S_GETXP;
            end
            S_GETXP: begin
                cmd.lat_xp = 1'b1;
                i_next     = start_reg;
                state_next = S_ISTART;
            end
            // new offset: fetch its sample, seed its weight
            S_ISTART: begin
                cmd.rd      = 1'b1;
                cmd.rd_addr = addr_i[AW-1:0];
                cmd.w_init  = 1'b1;
                cmd.w_one   = (i_reg != '0);
                j_next      = start_reg;
                state_next  = S_GETXI;
            end
            S_GETXI: begin
                cmd.lat_xi = 1'b1;
                state_next = S_JCHK;
            end
            // inner loop over the other stencil points
            S_JCHK: begin
                if (j_reg == end_reg) begin
                    state_next = S_TERM;
                end else if (j_reg == i_reg) begin
                    j_next = j_reg + OW'(1);
                end else begin
                    cmd.rd      = 1'b1;
                    cmd.rd_addr = addr_j[AW-1:0];
                    state_next  = S_GETXJ;
                end
            end
            S_GETXJ: begin
                cmd.lat_xj = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK: begin
                if (sts.diff_zero) begin
                    cmd.fault_set = FAULT_DIV0;
                    state_next    = S_EMIT;
                end else begin
                    cmd.div_go = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.arith_done) begin
                    cmd.w_from_div = 1'b1;
                    if (i_reg != '0 && j_reg != '0) begin
                        state_next = S_MGO;
                    end else begin
                        j_next     = j_reg + OW'(1);
                        state_next = S_JCHK;
                    end
                end
            end
            S_MGO: begin
                cmd.mul_d_go = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL: begin
                if (sts.arith_done) begin
                    cmd.w_from_mul = 1'b1;
                    j_next         = j_reg + OW'(1);
                    state_next     = S_JCHK;
                end
            end
            // weight times sample value into the sum
            S_TERM: begin
                cmd.mul_y_go = 1'b1;
                state_next   = S_TMUL;
            end
            S_TMUL: begin
                if (sts.arith_done) begin
                    cmd.acc_add = 1'b1;
                    if ((i_reg + OW'(1)) == end_reg) begin
                        state_next = S_EMIT;
                    end else begin
                        i_next     = i_reg + OW'(1);
                        state_next = S_ISTART;
                    end
                end
            end
            // hold the result word until taken
            S_EMIT: begin
                if (m_ready) begin
                    if (p_reg == AW'(BLOCK_POINTS - 1)) begin
                        p_next     = '0;
                        state_next = S_LOAD;
                    end else begin
                        p_next     = p_reg + AW'(1);
                        state_next = S_PSTART;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = (state_reg == S_EMIT);
    assign point   = p_reg;

endmodule

// File: design/nonuniform_grid_derivative_top.sv
// Top level: derivative on a nonuniform grid, APB register and stream ports
//
// Input channel s_*: one word per sample (abscissa, ordinate, Q16.16).
// A block of BLOCK_POINTS words is taken at one word per cycle. After the
// last word of a block the input stalls (s_ready low) while the block's
// derivatives are worked out and sent.
// Result channel m_*: BLOCK_POINTS words per block, in point order, with
// last_point on the final one and a fault code on each.
// All arithmetic runs through one serial unit: a divide works out 79
// quotient bits, a multiply is shift-add. For a width n, a point costs
// n(n-1) divides, (n-1)(n-2) multiplies for the weights and n multiplies
// for the sum, plus store reads. A too-wide stencil skips the arithmetic
// and gives each result with a width fault; an equal abscissa pair ends
// that point early. When the receiver stalls, the result word is held and
// nothing advances. Reset (aresetn low, synchronous) empties the block,
// sets the stencil width register to 5 and drops m_valid; stored samples
// are not cleared. APB: register 0 at address 0, stencil width, write
// only at idle.
`timescale 1ns / 1ps
module nonuniform_grid_derivative_top import ngd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_abscissa,
    input  logic signed [31:0] s_ordinate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_slope,
    output logic [5:0]         m_point_index,
    output logic               m_last_point,
    output logic [1:0]         m_fault
);

    localparam logic [1:0] ADDR_STENCIL = 2'd0;

    logic [2:0]    stencil_reg;
    logic [AW-1:0] point;
    ngd_cmd_t      cmd;
    ngd_sts_t      sts;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            stencil_reg <= 3'd5;
        else if (psel && penable && pwrite)
            stencil_reg <= pwdata[2:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STENCIL) ? {29'h0, stencil_reg} : 32'h0;

    ngd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stencil (stencil_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .point   (point),
        .cmd     (cmd),
        .sts     (sts)
    );

    ngd_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_abscissa (s_abscissa),
        .s_ordinate (s_ordinate),
        .sts        (sts),
        .slope      (m_slope),
        .fault      (m_fault)
    );

    assign m_point_index = 6'(point);
    assign m_last_point  = (point == AW'(BLOCK_POINTS - 1));

endmodule

// File: design/ngd_checker.sv
// Port-level checks of the derivative block, bound to the top level
`timescale 1ns / 1ps
`include "nonuniform_grid_derivative_top_defines.svh"
module ngd_checker import ngd_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_slope,
    input logic [5:0]         m_point_index,
    input logic               m_last_point,
    input logic [1:0]         m_fault
);

    // a block is either loading or sending, never both
    `NGD_ASSERT_IMP(a_no_overlap, m_valid, !s_ready)

    // a faulted result carries a zero slope
    `NGD_ASSERT_IMP(a_fault_zero, m_valid && m_fault != FAULT_NONE, m_slope == 32'sh0)

    // last flag only on the final point
    `NGD_ASSERT_IMP(a_last_idx, m_valid && m_last_point,
                    m_point_index == 6'(BLOCK_POINTS - 1))

    // a stalled result word holds
    `NGD_ASSERT_NXT(a_hold, m_valid && !m_ready,
                    m_valid && $stable(m_slope) && $stable(m_point_index))

endmodule

bind nonuniform_grid_derivative_top ngd_checker u_ngd_checker (.*);

// File: verif/tb_nonuniform_grid_derivative_top.sv
// Testbench for the nonuniform grid derivative block: stream stimulus, APB width set, slope checks
`timescale 1ns / 1ps
module tb_nonuniform_grid_derivative_top;
    import ngd_pkg::*;

    localparam logic [1:0]  REG_STENCIL = 2'd0;
    localparam int          IDLE_LIMIT  = 30000;
    localparam int          SETTLE      = 50;
    localparam logic [63:0] SAT_M       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_LO = -65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q32 = 64'sh1_0000_0000;

    typedef struct {
        logic [31:0] slope;
        logic [5:0]  idx;
        logic        last;
        logic [1:0]  fault;
    } slope_word_t;

    // directed table: typed rows carry an expected slope and fault for their point
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        bit          typed;
        logic [31:0] slope;
        logic [1:0]  fault;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_abscissa, s_ordinate;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_slope;
    logic [5:0]         m_point_index;
    logic               m_last_point;
    logic [1:0]         m_fault;

    nonuniform_grid_derivative_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_abscissa(s_abscissa), .s_ordinate(s_ordinate),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_slope(m_slope), .m_point_index(m_point_index),
        .m_last_point(m_last_point), .m_fault(m_fault)
    );

    // predictor state: current block and width register copy
    logic signed [63:0] blk_x [BLOCK_POINTS];
    logic signed [63:0] blk_y [BLOCK_POINTS];
    bit                 blk_typed [BLOCK_POINTS];
    logic [31:0]        blk_tslope [BLOCK_POINTS];
    logic [1:0]         blk_tfault [BLOCK_POINTS];
    int                 blk_fill;
    logic [2:0]         width_reg;

    slope_word_t pending_q[$];
    int          err_count;
    int          words_in;
    int          results_seen;
    int          idle_cycles;
    int          burst_left;
    int          rx_left;
    bit          rx_mode;

    // random block generator state
    int          gen_pos;
    int          gen_mode;
    logic [31:0] gen_x;
    logic [31:0] gen_step;
    logic [31:0] gen_hist [BLOCK_POINTS];
    int          dup_at;

    dir_row_t dir_tab [24];

    // ---------------- arithmetic of the predictor ----------------
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] clamp_signed(input logic [63:0] m, input bit neg);
        if (m > SAT_M)
            m = SAT_M;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t > SUM_HI)
            return SAT_M;
        if (t < SUM_LO)
            return -$signed(SAT_M);
        return t[63:0];
    endfunction

    // |w*d| >> sh, sh being 16 or 32
    function automatic logic signed [63:0] mul_q(input logic signed [63:0] w,
                                                 input logic signed [63:0] d, input int sh);
        bit neg;
        logic [63:0] uw, ud, hi, lo, a, b;
        int up;
        neg = (w < 0) != (d < 0);
        uw = mag64(w);
        ud = mag64(d);
        hi = uw >> 32;
        lo = uw & 64'hFFFF_FFFF;
        a = hi * ud;
        b = (lo * ud) >> sh;
        up = 32 - sh;
        if (up > 0) begin
            if (a > (SAT_M >> up))
                return clamp_signed(SAT_M, neg);
            a = a << up;
        end
        if (a > SAT_M - b)
            return clamp_signed(SAT_M, neg);
        return clamp_signed(a + b, neg);
    endfunction

    // Q32.32 divided by Q16.16, divisor nonzero
    function automatic logic signed [63:0] div_q(input logic signed [63:0] w,
                                                 input logic signed [63:0] d);
        bit neg;
        logic [63:0] uw, ud, q1, r1, hi, lo;
        neg = (w < 0) != (d < 0);
        uw = mag64(w);
        ud = mag64(d);
        q1 = uw / ud;
        r1 = uw % ud;
        if (q1 > (SAT_M >> 16))
            return clamp_signed(SAT_M, neg);
        hi = q1 << 16;
        lo = (r1 << 16) / ud;
        if (hi > SAT_M - lo)
            return clamp_signed(SAT_M, neg);
        return clamp_signed(hi + lo, neg);
    endfunction

    function automatic int width_in_use(input logic [2:0] r);
        int n;
        n = (r == 3'd0) ? 1 : int'(r);
        if ((n % 2) == 0)
            n = n - 1;
        if (n > MAX_STENCIL)
            n = ((MAX_STENCIL % 2) == 0) ? MAX_STENCIL - 1 : MAX_STENCIL;
        return n;
    endfunction

    // Lagrange derivative at point p; returns 0 on a zero divisor
    function automatic bit slope_at(input int p, input int n, output logic [31:0] s);
        int mid, lo_i, hi_i, i, j;
        logic signed [63:0] acc, w, d, xp, xi;
        logic [63:0] m;
        mid = (n - 1) / 2;
        acc = 0;
        s = 32'd0;
        xp = blk_x[p];
        if (p < mid) begin
            lo_i = -p;
            hi_i = n - p;
        end else if (BLOCK_POINTS - p - 1 < mid) begin
            lo_i = BLOCK_POINTS - n - p;
            hi_i = BLOCK_POINTS - p;
        end else begin
            lo_i = -mid;
            hi_i = mid + 1;
        end
        for (i = lo_i; i < hi_i; i++) begin
            w = (i != 0) ? ONE_Q32 : 64'sd0;
            xi = blk_x[p + i];
            for (j = lo_i; j < hi_i; j++) begin
                if (j == i)
                    continue;
                if (i == 0) begin
                    d = xp - blk_x[p + j];
                    if (d == 0)
                        return 1'b0;
                    w = sum_sat(w, div_q(ONE_Q32, d));
                    continue;
                end
                d = xi - blk_x[p + j];
                if (d == 0)
                    return 1'b0;
                w = div_q(w, d);
                if (j != 0)
                    w = mul_q(w, xp - blk_x[p + j], 16);
            end
            acc = sum_sat(acc, mul_q(w, blk_y[p + i], 32));
        end
        m = mag64(acc) >> 16;
        if (acc < 0)
            s = (m > 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        else
            s = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        return 1'b1;
    endfunction

    // take one accepted word into the block; a full block queues its slopes
    task automatic absorb_word(input logic [31:0] x, input logic [31:0] y,
                               input bit typed, input logic [31:0] ts, input logic [1:0] tf);
        int n, p;
        slope_word_t e;
        blk_x[blk_fill] = {{32{x[31]}}, x};
        blk_y[blk_fill] = {{32{y[31]}}, y};
        blk_typed[blk_fill] = typed;
        blk_tslope[blk_fill] = ts;
        blk_tfault[blk_fill] = tf;
        blk_fill++;
        words_in++;
        if (blk_fill == BLOCK_POINTS) begin
            blk_fill = 0;
            n = width_in_use(width_reg);
            for (p = 0; p < BLOCK_POINTS; p++) begin
                e.idx = 6'(p);
                e.last = (p == BLOCK_POINTS - 1);
                e.slope = 32'd0;
                if (n > BLOCK_POINTS)
                    e.fault = FAULT_WIDE;
                else if (slope_at(p, n, e.slope))
                    e.fault = FAULT_NONE;
                else begin
                    e.fault = FAULT_DIV0;
                    e.slope = 32'd0;
                end
                if (blk_typed[p]) begin
                    e.slope = blk_tslope[p];
                    e.fault = blk_tfault[p];
                end
                pending_q.push_back(e);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        err_count++;
    endtask

    // ---------------- sender ----------------
    // called at a rising edge; returns at the edge that accepted the word, or after a random idle gap that follows it
    task automatic send_word(input logic [31:0] x, input logic [31:0] y,
                             input bit typed, input logic [31:0] ts, input logic [1:0] tf);
        int gap;
        s_valid <= 1'b1;
        s_abscissa <= x;
        s_ordinate <= y;
        forever begin
            @(negedge aclk);
            if (s_ready)
                break;
        end
        @(posedge aclk);
        absorb_word(x, y, typed, ts, tf);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 14);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // next random word: mostly ordered grids, some raw noise, some with a repeated abscissa
    task automatic next_random(output logic [31:0] x, output logic [31:0] y);
        int k;
        if (gen_pos == 0) begin
            k = $urandom_range(0, 99);
            gen_mode = (k < 65) ? 0 : (k < 85) ? 1 : 2;
            gen_x = $urandom;
            case ($urandom_range(0, 2))
                0: gen_step = $urandom_range(1, 32'h0000_4000);
                1: gen_step = $urandom_range(32'h0000_4000, 32'h0020_0000);
                default: gen_step = $urandom_range(32'h0100_0000, 32'h1000_0000);
            endcase
            if ($urandom_range(0, 1))
                gen_step = -gen_step;
            dup_at = $urandom_range(1, BLOCK_POINTS - 1);
        end
        case (gen_mode)
            0: x = gen_x + gen_step * gen_pos;
            1: x = $urandom;
            default: x = (gen_pos == dup_at) ? gen_hist[$urandom_range(0, dup_at - 1)]
                                             : gen_x + gen_step * gen_pos;
        endcase
        gen_hist[gen_pos] = x;
        case ($urandom_range(0, 3))
            0: y = $urandom;
            1: y = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: y = $urandom_range(0, 32'h0004_0000) * (($urandom_range(0, 1)) ? 1 : -1);
        endcase
        gen_pos = (gen_pos + 1) % BLOCK_POINTS;
    endtask

    // ---------------- configuration ----------------
    task automatic write_width(input logic [2:0] w);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_STENCIL;
        pwdata <= {29'($urandom), w};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        width_reg = w;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every queued slope, then let the block settle
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ---------------- clock ----------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- receiver stall pattern ----------------
    always @(posedge aclk) begin
        if (rx_left <= 0) begin
            case ($urandom_range(0, 5))
                0: begin rx_mode <= 1'b1; rx_left <= $urandom_range(50, 200); end
                1, 2: begin rx_mode <= 1'b0; rx_left <= $urandom_range(1, 12); end
                default: begin rx_mode <= 1'b1; rx_left <= $urandom_range(1, 20); end
            endcase
            m_ready <= 1'b0;
        end else begin
            rx_left <= rx_left - 1;
            m_ready <= rx_mode;
        end
    end

    // ---------------- result checker and watchdog ----------------
    always @(negedge aclk) begin
        slope_word_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (pending_q.size() == 0) begin
                    report_mismatch("result with none expected", m_slope, 32'd0);
                end else begin
                    e = pending_q.pop_front();
                    if (m_slope !== e.slope)
                        report_mismatch($sformatf("slope of point %0d", e.idx), m_slope, e.slope);
                    if (m_point_index !== e.idx)
                        report_mismatch("point_index", 32'(m_point_index), 32'(e.idx));
                    if (m_last_point !== e.last)
                        report_mismatch("last_point", 32'(m_last_point), 32'(e.last));
                    if (m_fault !== e.fault)
                        report_mismatch("fault", 32'(m_fault), 32'(e.fault));
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        int r, ph, b;
        logic [31:0] x, y;
        logic [2:0] ph_width [9];
        int         ph_blocks [9];

        // block one: spread abscissae, zero ordinates, every slope zero
        dir_tab[0]  = '{32'h8000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[1]  = '{32'hA000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[2]  = '{32'hC000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[3]  = '{32'hE000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[4]  = '{32'h0000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[5]  = '{32'h2000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[6]  = '{32'h4000_0000, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        dir_tab[7]  = '{32'h7FFF_FFFF, 32'h0000_0000, 1, 32'd0, FAULT_NONE};
        // block two: one abscissa everywhere, divide by zero on every point
        dir_tab[8]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'd0, FAULT_DIV0};
        dir_tab[9]  = '{32'h7FFF_FFFF, 32'h8000_0000, 1, 32'd0, FAULT_DIV0};
        dir_tab[10] = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, FAULT_DIV0};
        dir_tab[11] = '{32'h7FFF_FFFF, 32'h0000_0001, 1, 32'd0, FAULT_DIV0};
        dir_tab[12] = '{32'h7FFF_FFFF, 32'h0000_0000, 1, 32'd0, FAULT_DIV0};
        dir_tab[13] = '{32'h7FFF_FFFF, 32'h0001_0000, 1, 32'd0, FAULT_DIV0};
        dir_tab[14] = '{32'h7FFF_FFFF, 32'hFFFF_0000, 1, 32'd0, FAULT_DIV0};
        dir_tab[15] = '{32'h7FFF_FFFF, 32'h5555_AAAA, 1, 32'd0, FAULT_DIV0};
        // block three: tight and huge spacings, extreme values, saturation
        dir_tab[16] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'd0, FAULT_NONE};
        dir_tab[17] = '{32'h8000_0001, 32'h8000_0000, 0, 32'd0, FAULT_NONE};
        dir_tab[18] = '{32'hFFFF_0000, 32'h7FFF_FFFF, 0, 32'd0, FAULT_NONE};
        dir_tab[19] = '{32'h0000_0000, 32'h8000_0000, 0, 32'd0, FAULT_NONE};
        dir_tab[20] = '{32'h0000_8000, 32'h0001_0000, 0, 32'd0, FAULT_NONE};
        dir_tab[21] = '{32'h0001_0000, 32'hFFFF_0000, 0, 32'd0, FAULT_NONE};
        dir_tab[22] = '{32'h7FFF_FFFE, 32'h7FFF_FFFF, 0, 32'd0, FAULT_NONE};
        dir_tab[23] = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'd0, FAULT_NONE};

        // width phases of the random part; extremes and even values among them
        ph_width  = '{3'd7, 3'd1, 3'd3, 3'd0, 3'd6, 3'd2, 3'd4, 3'd5, 3'd7};
        ph_blocks = '{2, 3, 3, 2, 2, 3, 3, 3, 2};

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_STENCIL;
        pwdata = 32'd0;
        s_valid = 1'b0;
        s_abscissa = 32'd0;
        s_ordinate = 32'd0;
        m_ready = 1'b0;
        rx_left = 0;
        rx_mode = 1'b1;
        err_count = 0;
        words_in = 0;
        results_seen = 0;
        idle_cycles = 0;
        blk_fill = 0;
        width_reg = 3'd5;
        gen_pos = 0;
        burst_left = 8;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset width
        for (r = 0; r < 24; r++)
            send_word(dir_tab[r].x, dir_tab[r].y, dir_tab[r].typed,
                      dir_tab[r].slope, dir_tab[r].fault);

        // random part, one width per phase
        for (ph = 0; ph < 9; ph++) begin
            drain();
            // in one phase the width changes with a block partly loaded
            if (ph == 4) begin
                for (b = 0; b < 3; b++) begin
                    next_random(x, y);
                    send_word(x, y, 0, 32'd0, FAULT_NONE);
                end
                drain();
            end
            write_width(ph_width[ph]);
            for (b = (ph == 4) ? 3 : 0; b < ph_blocks[ph] * BLOCK_POINTS; b++) begin
                next_random(x, y);
                send_word(x, y, 0, 32'd0, FAULT_NONE);
            end
        end
        drain();

        $display("Sent %0d sample words, checked %0d slope words over widths 0 to 7",
                 words_in, results_seen);
        $display("Covered equal abscissae, edge stencils, saturation and a mid-block width change");
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
